FILE: rtl/rv32imf_instruction_decoder_macros.svh
// Assertion helpers shared by the decoder RTL.
`ifndef RV32IMF_INSTRUCTION_DECODER_MACROS_SVH
`define RV32IMF_INSTRUCTION_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RV32D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RV32D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rv32d_pkg.sv
package rv32d_pkg;

   // Major opcodes (bits 6:0)
   localparam logic [6:0] OPC_LOAD     = 7'h03;
   localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
   localparam logic [6:0] OPC_OP_IMM   = 7'h13;
   localparam logic [6:0] OPC_AUIPC    = 7'h17;
   localparam logic [6:0] OPC_STORE    = 7'h23;
   localparam logic [6:0] OPC_STORE_FP = 7'h27;
   localparam logic [6:0] OPC_OP       = 7'h33;
   localparam logic [6:0] OPC_LUI      = 7'h37;
   localparam logic [6:0] OPC_OP_FP    = 7'h53;
   localparam logic [6:0] OPC_BRANCH   = 7'h63;
   localparam logic [6:0] OPC_JALR     = 7'h67;
   localparam logic [6:0] OPC_JAL      = 7'h6F;

   // funct3 codes
   localparam logic [2:0] F3_LB = 3'd0, F3_LH = 3'd1, F3_LW = 3'd2, F3_LBU = 3'd4, F3_LHU = 3'd5;
   localparam logic [2:0] F3_SB = 3'd0, F3_SH = 3'd1, F3_SW = 3'd2;
   localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
   localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
   localparam logic [2:0] F3_JALR = 3'd0;
   localparam logic [2:0] F3_FP_DYN = 3'd7;

   // funct7 codes
   localparam logic [6:0] F7_BASE  = 7'h00;
   localparam logic [6:0] F7_MEXT  = 7'h01;
   localparam logic [6:0] F7_ALT   = 7'h20;
   localparam logic [6:0] F7_FADD  = 7'h00;
   localparam logic [6:0] F7_FSUB  = 7'h04;
   localparam logic [6:0] F7_FMUL  = 7'h08;
   localparam logic [6:0] F7_FDIV  = 7'h0C;
   localparam logic [6:0] F7_FSQRT = 7'h2C;

   // Control bit sets: bit0 RegWrite .. bit8 Zero
   localparam logic [8:0] CTL_NONE    = 9'h000;
   localparam logic [8:0] CTL_LOAD    = 9'h01B;
   localparam logic [8:0] CTL_ALU_IMM = 9'h011;
   localparam logic [8:0] CTL_JALR    = 9'h0D1;
   localparam logic [8:0] CTL_STORE   = 9'h014;
   localparam logic [8:0] CTL_BRANCH  = 9'h020;
   localparam logic [8:0] CTL_ALU_REG = 9'h001;
   localparam logic [8:0] CTL_JAL     = 9'h051;

   localparam int RSP_TDATA_W = 80;

   typedef enum logic [2:0] {
      FMT_R = 3'd0,
      FMT_I = 3'd1,
      FMT_S = 3'd2,
      FMT_B = 3'd3,
      FMT_U = 3'd4,
      FMT_J = 3'd5
   } rv32d_fmt_type;

   typedef enum logic [5:0] {
      ID_NONE = 6'd0,
      ID_LB, ID_LH, ID_LW, ID_LBU, ID_LHU, ID_FLW,
      ID_ADDI, ID_SLLI, ID_SLTI, ID_SLTIU, ID_XORI, ID_SRLI, ID_SRAI, ID_ORI, ID_ANDI,
      ID_AUIPC, ID_SB, ID_SH, ID_SW, ID_FSW,
      ID_ADD, ID_SUB, ID_MUL, ID_SLL, ID_MULH, ID_SLT, ID_MULHSU, ID_SLTU, ID_MULHU,
      ID_XOR, ID_DIV, ID_SRL, ID_SRA, ID_DIVU, ID_OR, ID_REM, ID_AND, ID_REMU,
      ID_LUI, ID_BEQ, ID_BNE, ID_BLT, ID_BGE, ID_BLTU, ID_BGEU, ID_JALR, ID_JAL,
      ID_FADD, ID_FSUB, ID_FMUL, ID_FDIV, ID_FSQRT
   } rv32d_id_type;

   // Opcode-level decode handed to the field extractor
   typedef struct packed {
      logic          known;
      rv32d_id_type  op_id;
      rv32d_fmt_type fmt;
      logic [8:0]    ctl;
   } rv32d_dec_type;

   // One decoded result
   typedef struct packed {
      logic [8:0]    ctl;
      logic [31:0]   imm;
      logic [6:0]    f7;
      logic [2:0]    f3;
      logic [4:0]    rs2;
      logic [4:0]    rs1;
      logic [4:0]    rd;
      rv32d_fmt_type fmt;
      rv32d_id_type  op_id;
      logic          known;
   } rv32d_rsp_type;

endpackage

FILE: rtl/rv32d_opdec.sv
module rv32d_opdec (
   input  logic [31:0]            instr,
   output rv32d_pkg::rv32d_dec_type dec
);
   import rv32d_pkg::*;

   logic [6:0] opc;
   logic [2:0] f3;
   logic [6:0] f7;

   assign opc = instr[6:0];
   assign f3  = instr[14:12];
   assign f7  = instr[31:25];

   // Major opcode: format, control set and operation identity
   always_comb begin
      dec.known = 1'b1;
      dec.fmt   = FMT_R;
      dec.ctl   = CTL_NONE;
      dec.op_id = ID_NONE;
      case (opc)
         OPC_LOAD: begin
            dec.fmt = FMT_I;
            dec.ctl = CTL_LOAD;
            case (f3)
               F3_LB:   dec.op_id = ID_LB;
               F3_LH:   dec.op_id = ID_LH;
               F3_LW:   dec.op_id = ID_LW;
               F3_LBU:  dec.op_id = ID_LBU;
               F3_LHU:  dec.op_id = ID_LHU;
               default: dec.op_id = ID_NONE;
            endcase
         end
         OPC_LOAD_FP: begin
            dec.fmt   = FMT_I;
            dec.ctl   = CTL_LOAD;
            dec.op_id = (f3 == F3_LW) ? ID_FLW : ID_NONE;
         end
         OPC_OP_IMM: begin
            dec.fmt = FMT_I;
            dec.ctl = CTL_ALU_IMM;
            case (f3)
               F3_ADD:  dec.op_id = ID_ADDI;
               F3_SLL:  dec.op_id = (f7 == F7_BASE) ? ID_SLLI : ID_NONE;
               F3_SLT:  dec.op_id = ID_SLTI;
               F3_SLTU: dec.op_id = ID_SLTIU;
               F3_XOR:  dec.op_id = ID_XORI;
               F3_SR: begin
                  if (f7 == F7_BASE)     dec.op_id = ID_SRLI;
                  else if (f7 == F7_ALT) dec.op_id = ID_SRAI;
                  else                   dec.op_id = ID_NONE;
               end
               F3_OR:   dec.op_id = ID_ORI;
               default: dec.op_id = ID_ANDI;
            endcase
         end
         OPC_JALR: begin
            dec.fmt   = FMT_I;
            dec.ctl   = CTL_JALR;
            dec.op_id = (f3 == F3_JALR) ? ID_JALR : ID_NONE;
         end
         OPC_AUIPC: begin
            dec.fmt   = FMT_U;
            dec.ctl   = CTL_ALU_IMM;
            dec.op_id = ID_AUIPC;
         end
         OPC_LUI: begin
            dec.fmt   = FMT_U;
            dec.ctl   = CTL_ALU_IMM;
            dec.op_id = ID_LUI;
         end
         OPC_STORE: begin
            dec.fmt = FMT_S;
            dec.ctl = CTL_STORE;
            case (f3)
               F3_SB:   dec.op_id = ID_SB;
               F3_SH:   dec.op_id = ID_SH;
               F3_SW:   dec.op_id = ID_SW;
               default: dec.op_id = ID_NONE;
            endcase
         end
         OPC_STORE_FP: begin
            dec.fmt   = FMT_S;
            dec.ctl   = CTL_STORE;
            dec.op_id = (f3 == F3_SW) ? ID_FSW : ID_NONE;
         end
         OPC_BRANCH: begin
            dec.fmt = FMT_B;
            dec.ctl = CTL_BRANCH;
            case (f3)
               F3_BEQ:  dec.op_id = ID_BEQ;
               F3_BNE:  dec.op_id = ID_BNE;
               F3_BLT:  dec.op_id = ID_BLT;
               F3_BGE:  dec.op_id = ID_BGE;
               F3_BLTU: dec.op_id = ID_BLTU;
               F3_BGEU: dec.op_id = ID_BGEU;
               default: dec.op_id = ID_NONE;
            endcase
         end
         OPC_OP: begin
            dec.fmt = FMT_R;
            dec.ctl = CTL_ALU_REG;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD:  dec.op_id = ID_ADD;
                  F3_SLL:  dec.op_id = ID_SLL;
                  F3_SLT:  dec.op_id = ID_SLT;
                  F3_SLTU: dec.op_id = ID_SLTU;
                  F3_XOR:  dec.op_id = ID_XOR;
                  F3_SR:   dec.op_id = ID_SRL;
                  F3_OR:   dec.op_id = ID_OR;
                  default: dec.op_id = ID_AND;
               endcase
            end else if (f7 == F7_MEXT) begin
               // M extension shares the funct3 slots
               case (f3)
                  F3_ADD:  dec.op_id = ID_MUL;
                  F3_SLL:  dec.op_id = ID_MULH;
                  F3_SLT:  dec.op_id = ID_MULHSU;
                  F3_SLTU: dec.op_id = ID_MULHU;
                  F3_XOR:  dec.op_id = ID_DIV;
                  F3_SR:   dec.op_id = ID_DIVU;
                  F3_OR:   dec.op_id = ID_REM;
                  default: dec.op_id = ID_REMU;
               endcase
            end else if (f7 == F7_ALT) begin
               if (f3 == F3_ADD)     dec.op_id = ID_SUB;
               else if (f3 == F3_SR) dec.op_id = ID_SRA;
               else                  dec.op_id = ID_NONE;
            end
         end
         OPC_OP_FP: begin
            dec.fmt = FMT_R;
            dec.ctl = CTL_NONE;
            if (f3 == F3_FP_DYN) begin
               case (f7)
                  F7_FADD:  dec.op_id = ID_FADD;
                  F7_FSUB:  dec.op_id = ID_FSUB;
                  F7_FMUL:  dec.op_id = ID_FMUL;
                  F7_FDIV:  dec.op_id = ID_FDIV;
                  F7_FSQRT: dec.op_id = ID_FSQRT;
                  default:  dec.op_id = ID_NONE;
               endcase
            end
         end
         OPC_JAL: begin
            dec.fmt   = FMT_J;
            dec.ctl   = CTL_JAL;
            dec.op_id = ID_JAL;
         end
         default: dec.known = 1'b0;
      endcase
   end

endmodule

FILE: rtl/rv32d_fields.sv
module rv32d_fields (
   input  logic [31:0]              instr,
   input  rv32d_pkg::rv32d_dec_type dec,
   output rv32d_pkg::rv32d_rsp_type rsp
);
   import rv32d_pkg::*;

   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   logic [31:0] imm_sel;
   logic        has_rd;
   logic        has_rs1;
   logic        has_rs2;
   logic        has_f3;
   logic        is_r;

   // Immediate forms; I, S, B and J are sign-extended from bit 31, U is not
   assign imm_i = {{20{instr[31]}}, instr[31:20]};
   assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{20{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_u = {instr[31:12], 12'd0};
   assign imm_j = {{12{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};

   // Which fields the format carries; nothing when the opcode is unknown
   always_comb begin
      has_rd  = 1'b0;
      has_rs1 = 1'b0;
      has_rs2 = 1'b0;
      has_f3  = 1'b0;
      is_r    = 1'b0;
      imm_sel = 32'd0;
      if (dec.known) begin
         case (dec.fmt)
            FMT_R: begin
               has_rd  = 1'b1;
               has_rs1 = 1'b1;
               has_rs2 = 1'b1;
               has_f3  = 1'b1;
               is_r    = 1'b1;
            end
            FMT_I: begin
               has_rd  = 1'b1;
               has_rs1 = 1'b1;
               has_f3  = 1'b1;
               imm_sel = imm_i;
            end
            FMT_S: begin
               has_rs1 = 1'b1;
               has_rs2 = 1'b1;
               has_f3  = 1'b1;
               imm_sel = imm_s;
            end
            FMT_B: begin
               has_rs1 = 1'b1;
               has_rs2 = 1'b1;
               has_f3  = 1'b1;
               imm_sel = imm_b;
            end
            FMT_U: begin
               has_rd  = 1'b1;
               imm_sel = imm_u;
            end
            default: begin
               has_rd  = 1'b1;
               imm_sel = imm_j;
            end
         endcase
      end
   end

   assign rsp.known = dec.known;
   assign rsp.op_id = dec.op_id;
   assign rsp.fmt   = dec.known ? dec.fmt : FMT_R;
   assign rsp.ctl   = dec.ctl;
   assign rsp.imm   = imm_sel;
   assign rsp.rd    = has_rd  ? instr[11:7]  : 5'd0;
   assign rsp.rs1   = has_rs1 ? instr[19:15] : 5'd0;
   assign rsp.rs2   = has_rs2 ? instr[24:20] : 5'd0;
   assign rsp.f3    = has_f3  ? instr[14:12] : 3'd0;
   assign rsp.f7    = is_r    ? instr[31:25] : 7'd0;

endmodule

FILE: rtl/rv32imf_instruction_decoder.sv
// Channel   | Direction | Contents
// req_*     | in        | tdata[31:0] instruction_word
// rsp_*     | out       | tdata: decoded fields, opcode_known in bit 0
//
// One instruction per cycle sustained while rsp_tready stays high.
// The path is an input register, the opcode and field decode, then the result register.
// Reset (synchronous, active high) empties both registers; payload is not cleared.
// A stalled result stays in the result register while one more instruction waits
// in the input register; req_tready drops only when both are full.
module rv32imf_instruction_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // [31:0] instruction_word
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] opcode_known, [6:1] op_id, [9:7] format_kind, [14:10] dest_reg,
   // [19:15] src1_reg, [24:20] src2_reg, [27:25] funct3_field,
   // [34:28] funct7_field, [66:35] immediate_value, [75:67] control_bits, [79:76] zero
   output logic [rv32d_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import rv32d_pkg::*;

   `include "rv32imf_instruction_decoder_macros.svh"

   logic          req_vld_ff;
   logic          req_vld_in;
   logic [31:0]   req_word_ff;
   logic          rsp_vld_ff;
   logic          rsp_vld_in;
   rv32d_rsp_type rsp_data_ff;
   rv32d_rsp_type rsp_data_in;
   rv32d_dec_type dec;
   logic          advance;

   // Input stage moves forward when the result register is free or being drained
   assign advance    = req_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !req_vld_ff || advance;
   assign req_vld_in = (req_tvalid && req_tready) || (req_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_word_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Decode between the two registers
   rv32d_opdec u_opdec (
      .instr (req_word_ff),
      .dec   (dec)
   );

   rv32d_fields u_fields (
      .instr (req_word_ff),
      .dec   (dec),
      .rsp   (rsp_data_in)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

   // Checks
   `RV32D_ASSERT_NEXT(a_fill_output, clock, reset, req_vld_ff && !rsp_vld_ff, rsp_vld_ff,
      "held instruction did not reach an empty result register")
   `RV32D_ASSERT_NOW(a_unknown_zero, clock, reset, rsp_vld_ff && !rsp_data_ff.known,
      rsp_data_ff.op_id == ID_NONE && rsp_data_ff.imm == 32'd0 && rsp_data_ff.rd == 5'd0 &&
      rsp_data_ff.ctl == CTL_NONE, "unknown opcode produced nonzero fields")
   `RV32D_ASSERT_NOW(a_r_no_imm, clock, reset,
      rsp_vld_ff && rsp_data_ff.known && rsp_data_ff.fmt == FMT_R,
      rsp_data_ff.imm == 32'd0, "R format carried an immediate")
   `RV32D_ASSERT_NOW(a_id_known, clock, reset, rsp_vld_ff && rsp_data_ff.op_id != ID_NONE,
      rsp_data_ff.known, "operation identified on unknown opcode")

endmodule

FILE: verif/rv32imf_instruction_decoder_checker.sv
// Watches both channels of the decoder, predicts every decode and compares results in order.
module rv32imf_instruction_decoder_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // [31:0] instruction_word
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] opcode_known, [6:1] op_id, [9:7] format_kind, [14:10] dest_reg,
   // [19:15] src1_reg, [24:20] src2_reg, [27:25] funct3_field,
   // [34:28] funct7_field, [66:35] immediate_value, [75:67] control_bits, [79:76] zero
   input  logic [rv32d_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                                mismatch_count,
   output int                                outstanding_decodes
);

   import rv32d_pkg::*;

   typedef struct {
      logic [31:0]   word;
      rv32d_rsp_type decoded;
   } pending_decode_type;

   pending_decode_type expected_decodes [$];

   // Expected decode of one instruction word
   function automatic rv32d_rsp_type predict_decode(input logic [31:0] w);
      rv32d_rsp_type r;
      logic [6:0]    opc;
      logic [2:0]    f3;
      logic [6:0]    f7;
      opc = w[6:0];
      f3  = w[14:12];
      f7  = w[31:25];
      r = '0;
      r.known = 1'b1;
      r.op_id = ID_NONE;
      case (opc)
         OPC_LOAD: begin
            r.fmt = FMT_I;
            r.ctl = CTL_LOAD;
            case (f3)
               F3_LB:   r.op_id = ID_LB;
               F3_LH:   r.op_id = ID_LH;
               F3_LW:   r.op_id = ID_LW;
               F3_LBU:  r.op_id = ID_LBU;
               F3_LHU:  r.op_id = ID_LHU;
               default: r.op_id = ID_NONE;
            endcase
         end
         OPC_LOAD_FP: begin
            r.fmt = FMT_I;
            r.ctl = CTL_LOAD;
            r.op_id = (f3 == F3_LW) ? ID_FLW : ID_NONE;
         end
         OPC_OP_IMM: begin
            r.fmt = FMT_I;
            r.ctl = CTL_ALU_IMM;
            case (f3)
               F3_ADD:  r.op_id = ID_ADDI;
               F3_SLL:  r.op_id = (f7 == F7_BASE) ? ID_SLLI : ID_NONE;
               F3_SLT:  r.op_id = ID_SLTI;
               F3_SLTU: r.op_id = ID_SLTIU;
               F3_XOR:  r.op_id = ID_XORI;
               F3_SR: begin
                  if (f7 == F7_BASE) r.op_id = ID_SRLI;
                  else if (f7 == F7_ALT) r.op_id = ID_SRAI;
                  else r.op_id = ID_NONE;
               end
               F3_OR:   r.op_id = ID_ORI;
               default: r.op_id = ID_ANDI;
            endcase
         end
         OPC_JALR: begin
            r.fmt = FMT_I;
            r.ctl = CTL_JALR;
            r.op_id = (f3 == F3_JALR) ? ID_JALR : ID_NONE;
         end
         OPC_AUIPC: begin
            r.fmt = FMT_U;
            r.ctl = CTL_ALU_IMM;
            r.op_id = ID_AUIPC;
         end
         OPC_LUI: begin
            r.fmt = FMT_U;
            r.ctl = CTL_ALU_IMM;
            r.op_id = ID_LUI;
         end
         OPC_STORE: begin
            r.fmt = FMT_S;
            r.ctl = CTL_STORE;
            case (f3)
               F3_SB:   r.op_id = ID_SB;
               F3_SH:   r.op_id = ID_SH;
               F3_SW:   r.op_id = ID_SW;
               default: r.op_id = ID_NONE;
            endcase
         end
         OPC_STORE_FP: begin
            r.fmt = FMT_S;
            r.ctl = CTL_STORE;
            r.op_id = (f3 == F3_SW) ? ID_FSW : ID_NONE;
         end
         OPC_BRANCH: begin
            r.fmt = FMT_B;
            r.ctl = CTL_BRANCH;
            case (f3)
               F3_BEQ:  r.op_id = ID_BEQ;
               F3_BNE:  r.op_id = ID_BNE;
               F3_BLT:  r.op_id = ID_BLT;
               F3_BGE:  r.op_id = ID_BGE;
               F3_BLTU: r.op_id = ID_BLTU;
               F3_BGEU: r.op_id = ID_BGEU;
               default: r.op_id = ID_NONE;
            endcase
         end
         OPC_OP: begin
            r.fmt = FMT_R;
            r.ctl = CTL_ALU_REG;
            case (f7)
               F7_BASE: begin
                  case (f3)
                     F3_ADD:  r.op_id = ID_ADD;
                     F3_SLL:  r.op_id = ID_SLL;
                     F3_SLT:  r.op_id = ID_SLT;
                     F3_SLTU: r.op_id = ID_SLTU;
                     F3_XOR:  r.op_id = ID_XOR;
                     F3_SR:   r.op_id = ID_SRL;
                     F3_OR:   r.op_id = ID_OR;
                     default: r.op_id = ID_AND;
                  endcase
               end
               F7_MEXT: begin
                  case (f3)
                     F3_ADD:  r.op_id = ID_MUL;
                     F3_SLL:  r.op_id = ID_MULH;
                     F3_SLT:  r.op_id = ID_MULHSU;
                     F3_SLTU: r.op_id = ID_MULHU;
                     F3_XOR:  r.op_id = ID_DIV;
                     F3_SR:   r.op_id = ID_DIVU;
                     F3_OR:   r.op_id = ID_REM;
                     default: r.op_id = ID_REMU;
                  endcase
               end
               F7_ALT: begin
                  if (f3 == F3_ADD) r.op_id = ID_SUB;
                  else if (f3 == F3_SR) r.op_id = ID_SRA;
                  else r.op_id = ID_NONE;
               end
               default: r.op_id = ID_NONE;
            endcase
         end
         OPC_OP_FP: begin
            r.fmt = FMT_R;
            r.ctl = CTL_NONE;
            if (f3 == F3_FP_DYN) begin
               case (f7)
                  F7_FADD:  r.op_id = ID_FADD;
                  F7_FSUB:  r.op_id = ID_FSUB;
                  F7_FMUL:  r.op_id = ID_FMUL;
                  F7_FDIV:  r.op_id = ID_FDIV;
                  F7_FSQRT: r.op_id = ID_FSQRT;
                  default:  r.op_id = ID_NONE;
               endcase
            end
         end
         OPC_JAL: begin
            r.fmt = FMT_J;
            r.ctl = CTL_JAL;
            r.op_id = ID_JAL;
         end
         default: r.known = 1'b0;
      endcase

      // field extraction per format; unknown opcodes leave everything zero
      if (r.known) begin
         case (r.fmt)
            FMT_R: begin
               r.rd  = w[11:7];
               r.rs1 = w[19:15];
               r.rs2 = w[24:20];
               r.f3  = f3;
               r.f7  = f7;
            end
            FMT_I: begin
               r.rd  = w[11:7];
               r.rs1 = w[19:15];
               r.f3  = f3;
               r.imm = {{20{w[31]}}, w[31:20]};
            end
            FMT_S: begin
               r.rs1 = w[19:15];
               r.rs2 = w[24:20];
               r.f3  = f3;
               r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            FMT_B: begin
               r.rs1 = w[19:15];
               r.rs2 = w[24:20];
               r.f3  = f3;
               r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            FMT_U: begin
               r.rd  = w[11:7];
               r.imm = {w[31:12], 12'h000};
            end
            default: begin
               r.rd  = w[11:7];
               r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want, input logic [31:0] word);
      $display("MISMATCH %s: got %0h expected %0h (instruction %08h)", what, got, want, word);
      mismatch_count++;
   endtask

   task automatic compare_decode(input pending_decode_type want, input rv32d_rsp_type got,
                                 input logic [3:0] pad);
      rv32d_rsp_type exp;
      exp = want.decoded;
      if (got.known !== exp.known)
         report_mismatch("opcode_known", 32'(got.known), 32'(exp.known), want.word);
      if (got.op_id !== exp.op_id)
         report_mismatch("op_id", 32'(got.op_id), 32'(exp.op_id), want.word);
      if (got.fmt !== exp.fmt)
         report_mismatch("format_kind", 32'(got.fmt), 32'(exp.fmt), want.word);
      if (got.rd !== exp.rd)
         report_mismatch("dest_reg", 32'(got.rd), 32'(exp.rd), want.word);
      if (got.rs1 !== exp.rs1)
         report_mismatch("src1_reg", 32'(got.rs1), 32'(exp.rs1), want.word);
      if (got.rs2 !== exp.rs2)
         report_mismatch("src2_reg", 32'(got.rs2), 32'(exp.rs2), want.word);
      if (got.f3 !== exp.f3)
         report_mismatch("funct3_field", 32'(got.f3), 32'(exp.f3), want.word);
      if (got.f7 !== exp.f7)
         report_mismatch("funct7_field", 32'(got.f7), 32'(exp.f7), want.word);
      if (got.imm !== exp.imm)
         report_mismatch("immediate_value", got.imm, exp.imm, want.word);
      if (got.ctl !== exp.ctl)
         report_mismatch("control_bits", 32'(got.ctl), 32'(exp.ctl), want.word);
      if (pad !== 4'h0)
         report_mismatch("tdata padding", 32'(pad), 32'h0, want.word);
   endtask

   // sample both channels on the rising edge
   always @(posedge clock) begin
      pending_decode_type entry;
      rv32d_rsp_type got;
      if (reset) begin
         expected_decodes.delete();
         mismatch_count = 0;
         outstanding_decodes = 0;
      end else begin
         // input transaction: queue its predicted decode
         if (req_tvalid && req_tready) begin
            entry.word = req_tdata;
            entry.decoded = predict_decode(req_tdata);
            expected_decodes = {expected_decodes, entry};
         end
         // result transaction: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[75:0];
            if (expected_decodes.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], 32'h0, 32'h0);
            end else begin
               entry = expected_decodes.pop_front();
               compare_decode(entry, got, rsp_tdata[79:76]);
            end
         end
         outstanding_decodes = expected_decodes.size();
      end
   end

endmodule

FILE: verif/rv32imf_instruction_decoder_test.sv
// Stimulus and verdict for the decoder; checking lives in the checker module.
module rv32imf_instruction_decoder_test;

   import rv32d_pkg::*;

   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = 32'h0;  // [31:0] instruction_word
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] opcode_known, [6:1] op_id, [9:7] format_kind, [14:10] dest_reg,
   // [19:15] src1_reg, [24:20] src2_reg, [27:25] funct3_field,
   // [34:28] funct7_field, [66:35] immediate_value, [75:67] control_bits, [79:76] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding_decodes;
   int cycle_count = 0;
   bit quiet_mode  = 1'b0;

   logic [31:0] directed_words [$];

   rv32imf_instruction_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rv32imf_instruction_decoder_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .mismatch_count      (mismatch_count),
      .outstanding_decodes (outstanding_decodes)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // idle length: mostly short, a few long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) return $urandom_range(1, 3);
      if (pick < 19) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] encode_fields(input logic [6:0] f7, input logic [4:0] rs2,
                                                 input logic [4:0] rs1, input logic [2:0] f3,
                                                 input logic [4:0] rd, input logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   // append one word to the directed list
   task automatic add_directed(input logic [31:0] word);
      directed_words = {directed_words, word};
   endtask

   // mostly well-formed instructions with random operands, some raw noise
   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 99) < 12) return w;
      case ($urandom_range(0, 11))
         0:  w[6:0] = OPC_LOAD;
         1:  w[6:0] = OPC_LOAD_FP;
         2:  w[6:0] = OPC_OP_IMM;
         3:  w[6:0] = OPC_AUIPC;
         4:  w[6:0] = OPC_STORE;
         5:  w[6:0] = OPC_STORE_FP;
         6:  w[6:0] = OPC_OP;
         7:  w[6:0] = OPC_LUI;
         8:  w[6:0] = OPC_OP_FP;
         9:  w[6:0] = OPC_BRANCH;
         10: w[6:0] = OPC_JALR;
         default: w[6:0] = OPC_JAL;
      endcase
      // bias function codes toward listed combinations
      case (w[6:0])
         OPC_LOAD_FP, OPC_STORE_FP: begin
            if ($urandom_range(0, 3) != 0) w[14:12] = F3_LW;
         end
         OPC_JALR: begin
            if ($urandom_range(0, 3) != 0) w[14:12] = F3_JALR;
         end
         OPC_OP_IMM: begin
            if (w[14:12] == F3_SLL || w[14:12] == F3_SR) begin
               case ($urandom_range(0, 4))
                  0, 1:    w[31:25] = F7_BASE;
                  2, 3:    w[31:25] = F7_ALT;
                  default: ;
               endcase
            end
         end
         OPC_OP: begin
            case ($urandom_range(0, 8))
               0, 1, 2: w[31:25] = F7_BASE;
               3, 4, 5: w[31:25] = F7_MEXT;
               6, 7:    w[31:25] = F7_ALT;
               default: ;
            endcase
         end
         OPC_OP_FP: begin
            if ($urandom_range(0, 4) != 0) w[14:12] = F3_FP_DYN;
            case ($urandom_range(0, 5))
               0:       w[31:25] = F7_FADD;
               1:       w[31:25] = F7_FSUB;
               2:       w[31:25] = F7_FMUL;
               3:       w[31:25] = F7_FDIV;
               4:       w[31:25] = F7_FSQRT;
               default: ;
            endcase
         end
         default: ;
      endcase
      return w;
   endfunction

   // one input transaction, entered and left at a falling edge
   task automatic send_instruction(input logic [31:0] word);
      if (!quiet_mode && $urandom_range(0, 2) == 0) begin
         req_tvalid <= 1'b0;
         repeat (idle_length()) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // stop sending until every predicted decode has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding_decodes != 0) @(negedge clock);
   endtask

   // result side: ready most of the time, random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (reset || quiet_mode || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            repeat (idle_length() - 1) @(negedge clock);
         end
      end
   end

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: unknown opcodes, field extremes, reserved and unlisted codes
      add_directed(32'h0000_0000);
      add_directed(32'hFFFF_FFFF);
      add_directed(encode_fields(7'h40, 5'd0, 5'd31, F3_LB, 5'd1, OPC_LOAD));
      add_directed(encode_fields(7'h3F, 5'd31, 5'd0, 3'd6, 5'd31, OPC_LOAD));
      add_directed(encode_fields(7'h00, 5'd4, 5'd2, 3'd3, 5'd5, OPC_LOAD));
      add_directed(encode_fields(7'h7F, 5'd31, 5'd1, F3_LW, 5'd2, OPC_LOAD_FP));
      add_directed(encode_fields(7'h00, 5'd0, 5'd1, F3_LB, 5'd2, OPC_LOAD_FP));
      add_directed(encode_fields(F7_BASE, 5'd31, 5'd3, F3_SLL, 5'd4, OPC_OP_IMM));
      add_directed(encode_fields(7'h01, 5'd1, 5'd3, F3_SLL, 5'd4, OPC_OP_IMM));
      add_directed(encode_fields(F7_ALT, 5'd7, 5'd9, F3_SR, 5'd10, OPC_OP_IMM));
      add_directed(encode_fields(7'h21, 5'd7, 5'd9, F3_SR, 5'd10, OPC_OP_IMM));
      add_directed(encode_fields(F7_BASE, 5'd3, 5'd9, F3_SR, 5'd10, OPC_OP_IMM));
      add_directed(32'hFFFF_FF97);  // auipc, all upper bits set
      add_directed(32'h8000_00B7);  // lui, sign bit only
      add_directed(encode_fields(7'h40, 5'd5, 5'd6, F3_SB, 5'd0, OPC_STORE));
      add_directed(encode_fields(7'h3F, 5'd31, 5'd31, 3'd3, 5'd31, OPC_STORE));
      add_directed(encode_fields(7'h00, 5'd1, 5'd2, F3_SW, 5'd3, OPC_STORE_FP));
      add_directed(encode_fields(7'h00, 5'd1, 5'd2, F3_SH, 5'd3, OPC_STORE_FP));
      add_directed(encode_fields(F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP));
      add_directed(encode_fields(F7_ALT, 5'd1, 5'd2, F3_SLL, 5'd3, OPC_OP));
      add_directed(encode_fields(7'h7F, 5'd31, 5'd31, F3_AND, 5'd31, OPC_OP));
      add_directed(encode_fields(F7_MEXT, 5'd8, 5'd9, F3_SLTU, 5'd10, OPC_OP));
      add_directed(encode_fields(F7_FSQRT, 5'd0, 5'd5, F3_FP_DYN, 5'd6, OPC_OP_FP));
      add_directed(encode_fields(F7_FADD, 5'd1, 5'd5, 3'd0, 5'd6, OPC_OP_FP));
      add_directed(encode_fields(7'h10, 5'd1, 5'd5, F3_FP_DYN, 5'd6, OPC_OP_FP));
      add_directed(encode_fields(7'h7F, 5'd31, 5'd31, F3_BGEU, 5'd31, OPC_BRANCH));
      add_directed(encode_fields(7'h00, 5'd2, 5'd1, 3'd2, 5'd0, OPC_BRANCH));
      add_directed(encode_fields(7'h40, 5'd0, 5'd1, F3_JALR, 5'd1, OPC_JALR));
      add_directed(encode_fields(7'h00, 5'd0, 5'd1, 3'd1, 5'd1, OPC_JALR));
      add_directed(32'hFFFF_F0EF);  // jal, offset of -2
      add_directed(32'h7FFF_F06F);  // jal, most positive offset
      foreach (directed_words[i]) send_instruction(directed_words[i]);
      wait_for_results();

      // random: a back-to-back stretch and one full drain midway
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet_mode = (i >= 300 && i < 400);
         if (i == 550) wait_for_results();
         send_instruction(random_instruction());
      end
      quiet_mode = 1'b0;

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
